// ===== rtl/bthd_pkg.sv =====
// Shared types, codes and the record kind lookup for the BER tag/length header decoder.
// No dependencies.
package bthd_pkg;

    typedef enum logic [2:0] {
        ERR_OK         = 3'd0,
        ERR_TAG_TRUNC  = 3'd1,
        ERR_TAG_RANGE  = 3'd2,
        ERR_LEN_TRUNC  = 3'd3,
        ERR_LEN_OVFL   = 3'd4,
        ERR_REC_EXCEED = 3'd5
    } t_err;

    typedef enum logic [3:0] {
        KIND_SEQUENCE    = 4'd0,
        KIND_SET         = 4'd1,
        KIND_CONSTRUCTED = 4'd2,
        KIND_INTEGER     = 4'd3,
        KIND_ENUMERATED  = 4'd4,
        KIND_OCTET_STR   = 4'd5,
        KIND_BOOLEAN     = 4'd6,
        KIND_NULL        = 4'd7,
        KIND_GENERIC     = 4'd8
    } t_kind;

    localparam logic [1:0] CLASS_UNIVERSAL = 2'd0;
    localparam logic [4:0] TAG_EXTENDED    = 5'h1f;

    localparam logic [6:0] TAG_BOOLEAN    = 7'd1;
    localparam logic [6:0] TAG_INTEGER    = 7'd2;
    localparam logic [6:0] TAG_OCTET_STR  = 7'd4;
    localparam logic [6:0] TAG_NULL       = 7'd5;
    localparam logic [6:0] TAG_ENUMERATED = 7'd10;
    localparam logic [6:0] TAG_SEQUENCE   = 7'd16;
    localparam logic [6:0] TAG_SET        = 7'd17;

    function automatic t_kind kind_of(input logic [1:0] tag_class, input logic constructed,
                                      input logic [6:0] tag_number);
        t_kind k;
        k = KIND_GENERIC;
        if (constructed) begin
            if (tag_class == CLASS_UNIVERSAL && tag_number == TAG_SEQUENCE) begin
                k = KIND_SEQUENCE;
            end else if (tag_class == CLASS_UNIVERSAL && tag_number == TAG_SET) begin
                k = KIND_SET;
            end else begin
                k = KIND_CONSTRUCTED;
            end
        end else if (tag_class == CLASS_UNIVERSAL) begin
            case (tag_number)
                TAG_INTEGER:    k = KIND_INTEGER;
                TAG_ENUMERATED: k = KIND_ENUMERATED;
                TAG_OCTET_STR:  k = KIND_OCTET_STR;
                TAG_BOOLEAN:    k = KIND_BOOLEAN;
                TAG_NULL:       k = KIND_NULL;
                default:        k = KIND_GENERIC;
            endcase
        end
        return k;
    endfunction

endpackage

// ===== rtl/bthd_if.sv =====
// Valid/ready channel interfaces for the header decoder: byte input and header result.
// Uses no package.
interface bthd_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  in_byte;
    logic        start_req;
    logic [31:0] avail_len;

    modport source (output valid, output in_byte, output start_req, output avail_len,
                    input ready);
    modport sink (input valid, input in_byte, input start_req, input avail_len,
                  output ready);
    modport monitor (input valid, input ready, input in_byte, input start_req,
                     input avail_len);
endinterface

interface bthd_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  error_code;
    logic [1:0]  tag_class;
    logic        constructed;
    logic [6:0]  tag_number;
    logic [3:0]  record_kind;
    logic [2:0]  header_length;
    logic [31:0] value_length;
    logic [32:0] total_length;

    modport source (output valid, output error_code, output tag_class, output constructed,
                    output tag_number, output record_kind, output header_length,
                    output value_length, output total_length, input ready);
    modport sink (input valid, input error_code, input tag_class, input constructed,
                  input tag_number, input record_kind, input header_length,
                  input value_length, input total_length, output ready);
    modport monitor (input valid, input ready, input error_code, input tag_class,
                     input constructed, input tag_number, input record_kind,
                     input header_length, input value_length, input total_length);
endinterface

// ===== rtl/ber_tlv_header_decoder_core.sv =====
// Top level of the BER tag/length header decoder.
// Depends on bthd_pkg and the channel interfaces in bthd_if.sv.
//
// One header byte per transaction; a byte with start_req set opens a record and
// latches avail_len. The block emits one result per record when the header is
// complete or an error is found, and nothing for bytes between a result and
// the next start. Each byte passes an input register, combinational decode
// logic that updates the header registers, and the result register, so a
// byte is taken every cycle while the input side does not stall, and a
// result is registered from its last byte. The input side stalls only while
// the result register holds an untaken result and the input register is full.
module ber_tlv_header_decoder_core #(
    parameter int MAX_LENGTH_BYTES = 4
) (
    input logic        i_clk,
    input logic        i_rst_n,
    bthd_in_if.sink    i_in,
    bthd_out_if.source o_out
);

    localparam int HCW = $clog2(MAX_LENGTH_BYTES + 4);
    localparam int LW  = $clog2(MAX_LENGTH_BYTES + 1);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_TAG2,
        PH_LEN_FIRST,
        PH_LEN_MORE
    } t_phase;

    // input register
    logic        r_in_valid;
    logic [7:0]  r_byte;
    logic        r_start;
    logic [31:0] r_avail_in;

    // header state
    t_phase          r_phase,  n_phase;
    logic [1:0]      r_class,  n_class;
    logic            r_cons,   n_cons;
    logic [6:0]      r_tag,    n_tag;
    logic [HCW-1:0]  r_hc,     n_hc;
    logic [LW-1:0]   r_left,   n_left;
    logic [31:0]     r_acc,    n_acc;
    logic [31:0]     r_avail,  n_avail;

    // result register
    logic        r_out_valid;
    bthd_pkg::t_err  r_err;
    logic [1:0]  r_o_class;
    logic        r_o_cons;
    logic [6:0]  r_o_tag;
    bthd_pkg::t_kind r_o_kind;
    logic [2:0]  r_o_hlen;
    logic [31:0] r_o_vlen;
    logic [32:0] r_o_total;

    logic            w_adv;
    logic            w_fire;
    logic            w_fin;
    logic            w_res_v;
    bthd_pkg::t_err  w_err;
    logic [6:0]      w_n;
    logic [32:0]     w_total;
    logic [32:0]     w_need;

    assign w_adv      = !r_out_valid || o_out.ready;
    assign w_fire     = r_in_valid && w_adv;
    assign i_in.ready = !r_in_valid || w_adv;

    always_comb begin
        n_phase = r_phase;
        n_class = r_class;
        n_cons  = r_cons;
        n_tag   = r_tag;
        n_hc    = r_hc;
        n_left  = r_left;
        n_acc   = r_acc;
        n_avail = r_avail;
        w_fin   = 1'b0;
        w_res_v = 1'b0;
        w_err   = bthd_pkg::ERR_OK;
        w_n     = r_byte[6:0];
        w_need  = 33'(r_hc) + 33'd1 + 33'(w_n);
        if (r_start) begin
            n_avail = r_avail_in;
            n_class = r_byte[7:6];
            n_cons  = r_byte[5];
            n_tag   = 7'd0;
            n_acc   = 32'd0;
            n_left  = '0;
            n_hc    = HCW'(1);
            n_phase = PH_IDLE;
            if (r_avail_in == 32'd0) begin
                w_res_v = 1'b1;
                w_err   = bthd_pkg::ERR_TAG_TRUNC;
            end else if (r_byte[4:0] == bthd_pkg::TAG_EXTENDED) begin
                if (r_avail_in < 32'd2) begin
                    w_res_v = 1'b1;
                    w_err   = bthd_pkg::ERR_TAG_TRUNC;
                end else begin
                    n_phase = PH_TAG2;
                end
            end else begin
                n_tag = {2'b00, r_byte[4:0]};
                if (r_avail_in < 32'd2) begin
                    w_res_v = 1'b1;
                    w_err   = bthd_pkg::ERR_LEN_TRUNC;
                end else begin
                    n_phase = PH_LEN_FIRST;
                end
            end
        end else begin
            case (r_phase)
                PH_TAG2: begin
                    if (r_byte[7]) begin
                        w_res_v = 1'b1;
                        w_err   = bthd_pkg::ERR_TAG_RANGE;
                    end else begin
                        n_tag = r_byte[6:0];
                        n_hc  = HCW'(2);
                        if (r_avail < 32'd3) begin
                            w_res_v = 1'b1;
                            w_err   = bthd_pkg::ERR_LEN_TRUNC;
                        end else begin
                            n_phase = PH_LEN_FIRST;
                        end
                    end
                end
                PH_LEN_FIRST: begin
                    n_hc = r_hc + HCW'(1);
                    if (!r_byte[7]) begin
                        n_acc = {24'd0, r_byte};
                        w_fin = 1'b1;
                    end else if ({1'b0, r_avail} < w_need) begin
                        w_res_v = 1'b1;
                        w_err   = bthd_pkg::ERR_LEN_TRUNC;
                    end else if (w_n > 7'(MAX_LENGTH_BYTES)) begin
                        w_res_v = 1'b1;
                        w_err   = bthd_pkg::ERR_LEN_OVFL;
                    end else if (w_n == 7'd0) begin
                        n_acc = 32'd0;
                        w_fin = 1'b1;
                    end else begin
                        n_left  = LW'(w_n);
                        n_phase = PH_LEN_MORE;
                    end
                end
                PH_LEN_MORE: begin
                    if (r_acc[31:24] != 8'd0) begin
                        w_res_v = 1'b1;
                        w_err   = bthd_pkg::ERR_LEN_OVFL;
                    end else begin
                        n_acc  = {r_acc[23:0], r_byte};
                        n_hc   = r_hc + HCW'(1);
                        n_left = r_left - LW'(1);
                        if (n_left == '0) begin
                            w_fin = 1'b1;
                        end
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
        w_total = 33'(n_hc) + {1'b0, n_acc};
        if (w_fin) begin
            w_res_v = 1'b1;
            if (w_total > {1'b0, n_avail}) begin
                w_err = bthd_pkg::ERR_REC_EXCEED;
            end
        end
        if (w_res_v) begin
            n_phase = PH_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_IDLE;
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_in_valid <= 1'b1;
            end else if (w_fire) begin
                r_in_valid <= 1'b0;
            end
            if (w_fire) begin
                r_phase <= n_phase;
            end
            if (w_fire && w_res_v) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_byte     <= i_in.in_byte;
            r_start    <= i_in.start_req;
            r_avail_in <= i_in.avail_len;
        end
        if (w_fire) begin
            r_class <= n_class;
            r_cons  <= n_cons;
            r_tag   <= n_tag;
            r_hc    <= n_hc;
            r_left  <= n_left;
            r_acc   <= n_acc;
            r_avail <= n_avail;
        end
        if (w_fire && w_res_v) begin
            r_err <= w_err;
            if (w_err == bthd_pkg::ERR_OK) begin
                r_o_class <= n_class;
                r_o_cons  <= n_cons;
                r_o_tag   <= n_tag;
                r_o_kind  <= bthd_pkg::kind_of(n_class, n_cons, n_tag);
                r_o_hlen  <= n_hc[2:0];
                r_o_vlen  <= n_acc;
                r_o_total <= w_total;
            end else begin
                r_o_class <= 2'd0;
                r_o_cons  <= 1'b0;
                r_o_tag   <= 7'd0;
                r_o_kind  <= bthd_pkg::KIND_SEQUENCE;
                r_o_hlen  <= 3'd0;
                r_o_vlen  <= 32'd0;
                r_o_total <= 33'd0;
            end
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.error_code    = r_err;
    assign o_out.tag_class     = r_o_class;
    assign o_out.constructed   = r_o_cons;
    assign o_out.tag_number    = r_o_tag;
    assign o_out.record_kind   = r_o_kind;
    assign o_out.header_length = r_o_hlen;
    assign o_out.value_length  = r_o_vlen;
    assign o_out.total_length  = r_o_total;

endmodule

// ===== rtl/bthd_checker.sv =====
// Port-level checks for ber_tlv_header_decoder_core, attached by bind.
// Depends on bthd_pkg; watches the result channel of the top level.
module bthd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic [2:0]  i_error_code,
    input logic [1:0]  i_tag_class,
    input logic        i_constructed,
    input logic [6:0]  i_tag_number,
    input logic [2:0]  i_header_length,
    input logic [31:0] i_value_length,
    input logic [32:0] i_total_length
);

    // stalled result stays valid with stable error code and total length
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_total_length)
            && $stable(i_error_code))
        else $error("result changed while stalled");

    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("result valid after reset");

    a_err_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> i_error_code <= bthd_pkg::ERR_REC_EXCEED)
        else $error("error code out of range");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_error_code != bthd_pkg::ERR_OK |->
            i_tag_class == 2'd0 && !i_constructed && i_tag_number == 7'd0
            && i_header_length == 3'd0 && i_value_length == 32'd0
            && i_total_length == 33'd0)
        else $error("error transaction carries header fields");

    a_ok_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_error_code == bthd_pkg::ERR_OK |->
            i_total_length > {1'b0, i_value_length})
        else $error("total length not above value length");

endmodule

bind ber_tlv_header_decoder_core bthd_checker u_bthd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (o_out.valid),
    .i_ready         (o_out.ready),
    .i_error_code    (o_out.error_code),
    .i_tag_class     (o_out.tag_class),
    .i_constructed   (o_out.constructed),
    .i_tag_number    (o_out.tag_number),
    .i_header_length (o_out.header_length),
    .i_value_length  (o_out.value_length),
    .i_total_length  (o_out.total_length)
);
